FILE: design/linear_probe_hash_set_unit_defines.svh
// ----------------------------------------------------------------------------
// linear probe hash set assertion macros
// Shared property wrappers for the hash set unit; empty when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef LINEAR_PROBE_HASH_SET_UNIT_DEFINES_SVH
`define LINEAR_PROBE_HASH_SET_UNIT_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication
`define LPHS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lphs assertion failed");
// next-cycle implication
`define LPHS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lphs assertion failed");
`else
`define LPHS_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define LPHS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

FILE: design/lphs_pkg.sv
// ----------------------------------------------------------------------------
// lphs_pkg
// Types and codes shared by the linear probe hash set unit.
// ----------------------------------------------------------------------------
package lphs_pkg;

   // requested operation
   typedef enum logic [1:0] {
      ACT_FIND   = 2'd0,
      ACT_INSERT = 2'd1,
      ACT_REMOVE = 2'd2
   } action_type;

   // result status
   typedef enum logic [2:0] {
      ST_INSERTED = 3'd0,
      ST_PRESENT  = 3'd1,
      ST_FOUND    = 3'd2,
      ST_NOTFOUND = 3'd3,
      ST_REMOVED  = 3'd4,
      ST_FULL     = 3'd5
   } status_type;

   // controller states
   typedef enum logic [3:0] {
      FSM_CLEAR,
      FSM_IDLE,
      FSM_MOD,
      FSM_RD,
      FSM_EV,
      FSM_INS,
      FSM_BK_RD,
      FSM_BK_EV
   } fsm_type;

   localparam int MAX_ENTRIES_RESET = 512;

   // request payload
   typedef struct packed {
      logic [1:0]  action;
      logic [31:0] key;
      logic [31:0] hash_value;
   } req_type;

   // result payload
   typedef struct packed {
      status_type  status;
      logic [9:0]  slot_index;
      logic [10:0] entry_count;
   } rsp_type;

endpackage

FILE: design/linear_probe_hash_set_unit.sv
// ----------------------------------------------------------------------------
// linear_probe_hash_set_unit
// Open-addressing key set with linear probing and continuation marks.
// ----------------------------------------------------------------------------
//  channel   ports                      direction  handshake
//  request   start busy req_item        in         start && !busy
//  result    rsp_valid rsp_item         out        one-cycle strobe
//  config    csr_we csr_wdata           in         write on csr_we
//
//  after reset a clearing pass over all CAPACITY slots runs with busy high
//  home slot: low bits for power-of-two CAPACITY, else a reciprocal multiply
//  each probed slot takes a memory read state, then an evaluate/write-back state
//  insert adds a state for placing the key; remove walks back with a read and an evaluate state per slot
//  result strobe comes in the cycle busy drops; the receiver cannot stall
// ----------------------------------------------------------------------------
`include "linear_probe_hash_set_unit_defines.svh"

module linear_probe_hash_set_unit #(
   parameter int CAPACITY = 1024,
   parameter int KEY_BITS = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  lphs_pkg::req_type req_item,
   output logic             rsp_valid,
   output lphs_pkg::rsp_type rsp_item,
   input  logic             csr_we,
   input  logic [9:0]       csr_wdata
);

   localparam int AW = $clog2(CAPACITY);
   localparam int MW = KEY_BITS + 2;
   localparam logic [AW-1:0] LAST = AW'(CAPACITY - 1);

   lphs_pkg::fsm_type    state_ff, state_in;
   lphs_pkg::action_type act_ff, act_in;
   lphs_pkg::rsp_type    res_ff, res_in;
   logic [AW-1:0]        clr_ff, clr_in;
   logic [AW-1:0]        pos_ff, pos_in;
   logic [AW-1:0]        n_ff, n_in;
   logic [AW-1:0]        reuse_ff, reuse_in;
   logic [AW-1:0]        target_ff, target_in;
   logic                 have_reuse_ff, have_reuse_in;
   logic                 have_end_ff, have_end_in;
   logic [KEY_BITS-1:0]  key_ff, key_in;
   logic [10:0]          count_ff, count_in;
   logic [9:0]           max_ff;
   logic                 rsp_valid_ff, rsp_valid_in;

   logic                 mem_we;
   logic [AW-1:0]        mem_waddr, mem_raddr;
   logic [MW-1:0]        mem_wdata, mem_rdata;
   logic                 mod_start, mod_done;
   logic [AW-1:0]        mod_rem;

   logic                 rd_occ, rd_cont, rd_match;
   logic [KEY_BITS-1:0]  rd_key;
   logic                 last_step;
   logic [AW-1:0]        ins_tgt;
   logic [63:0]          key_wide;

   function automatic logic [AW-1:0] next_slot(logic [AW-1:0] s);
      return (s == LAST) ? '0 : s + AW'(1);
   endfunction

   function automatic logic [AW-1:0] prev_slot(logic [AW-1:0] s);
      return (s == '0) ? LAST : s - AW'(1);
   endfunction

   function automatic logic [9:0] slot_of(logic [AW-1:0] s);
      logic [31:0] w;
      w = 32'(s);
      return w[9:0];
   endfunction

   lphs_mem #(
      .DEPTH (CAPACITY),
      .WIDTH (MW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   lphs_mod #(
      .CAPACITY (CAPACITY)
   ) u_mod (
      .clock      (clock),
      .reset      (reset),
      .start      (mod_start),
      .hash_value (req_item.hash_value),
      .done       (mod_done),
      .rem        (mod_rem)
   );

   // slot fields from the read port
   assign rd_occ    = mem_rdata[MW-1];
   assign rd_cont   = mem_rdata[MW-2];
   assign rd_key    = mem_rdata[KEY_BITS-1:0];
   assign rd_match  = rd_occ && (rd_key == key_ff);
   assign last_step = (n_ff == LAST);
   assign ins_tgt   = have_reuse_ff ? reuse_ff : target_ff;
   assign key_wide  = 64'(req_item.key);

   // probe sequencer
   always_comb begin
      state_in      = state_ff;
      act_in        = act_ff;
      res_in        = res_ff;
      clr_in        = clr_ff;
      pos_in        = pos_ff;
      n_in          = n_ff;
      reuse_in      = reuse_ff;
      target_in     = target_ff;
      have_reuse_in = have_reuse_ff;
      have_end_in   = have_end_ff;
      key_in        = key_ff;
      count_in      = count_ff;
      rsp_valid_in  = 1'b0;
      mem_we        = 1'b0;
      mem_waddr     = pos_ff;
      mem_wdata     = '0;
      mem_raddr     = pos_ff;
      mod_start     = 1'b0;

      unique case (state_ff)
         lphs_pkg::FSM_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            if (clr_ff == LAST) begin
               state_in = lphs_pkg::FSM_IDLE;
            end else begin
               clr_in = clr_ff + AW'(1);
            end
         end
         lphs_pkg::FSM_IDLE: begin
            if (start) begin
               act_in        = lphs_pkg::action_type'(req_item.action);
               key_in        = key_wide[KEY_BITS-1:0];
               mod_start     = 1'b1;
               n_in          = '0;
               have_reuse_in = 1'b0;
               have_end_in   = 1'b0;
               state_in      = lphs_pkg::FSM_MOD;
            end
         end
         lphs_pkg::FSM_MOD: begin
            if (mod_done) begin
               pos_in = mod_rem;
               unique case (act_ff)
                  lphs_pkg::ACT_FIND, lphs_pkg::ACT_INSERT, lphs_pkg::ACT_REMOVE: begin
                     state_in = lphs_pkg::FSM_RD;
                  end
                  default: begin
                     res_in.status     = lphs_pkg::ST_NOTFOUND;
                     res_in.slot_index = '0;
                     rsp_valid_in      = 1'b1;
                     state_in          = lphs_pkg::FSM_IDLE;
                  end
               endcase
            end
         end
         lphs_pkg::FSM_RD: begin
            mem_raddr = pos_ff;
            state_in  = lphs_pkg::FSM_EV;
         end
         lphs_pkg::FSM_EV: begin
            // default next: advance to the following slot
            pos_in   = next_slot(pos_ff);
            n_in     = n_ff + AW'(1);
            state_in = lphs_pkg::FSM_RD;
            unique case (act_ff)
               lphs_pkg::ACT_FIND: begin
                  if (rd_match) begin
                     res_in.status     = lphs_pkg::ST_FOUND;
                     res_in.slot_index = slot_of(pos_ff);
                     rsp_valid_in      = 1'b1;
                  end else if (!rd_cont || last_step) begin
                     res_in.status     = lphs_pkg::ST_NOTFOUND;
                     res_in.slot_index = '0;
                     rsp_valid_in      = 1'b1;
                  end
               end
               lphs_pkg::ACT_INSERT: begin
                  if (rd_match) begin
                     res_in.status     = lphs_pkg::ST_PRESENT;
                     res_in.slot_index = slot_of(pos_ff);
                     rsp_valid_in      = 1'b1;
                  end else if (rd_occ) begin
                     // mark that probing continues past this slot
                     mem_we    = 1'b1;
                     mem_wdata = {1'b1, 1'b1, rd_key};
                     if (last_step) begin
                        state_in = lphs_pkg::FSM_INS;
                     end
                  end else if (!rd_cont) begin
                     have_end_in = 1'b1;
                     target_in   = pos_ff;
                     state_in    = lphs_pkg::FSM_INS;
                  end else begin
                     if (!have_reuse_ff) begin
                        have_reuse_in = 1'b1;
                        reuse_in      = pos_ff;
                     end
                     if (last_step) begin
                        state_in = lphs_pkg::FSM_INS;
                     end
                  end
               end
               lphs_pkg::ACT_REMOVE: begin
                  if (rd_match) begin
                     mem_we            = 1'b1;
                     mem_wdata         = {1'b0, rd_cont, rd_key};
                     count_in          = (count_ff != '0) ? count_ff - 11'd1 : count_ff;
                     res_in.status     = lphs_pkg::ST_REMOVED;
                     res_in.slot_index = slot_of(pos_ff);
                     pos_in            = pos_ff;
                     n_in              = '0;
                     if (rd_cont) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        state_in = lphs_pkg::FSM_BK_RD;
                     end
                  end else if (!rd_cont || last_step) begin
                     res_in.status     = lphs_pkg::ST_NOTFOUND;
                     res_in.slot_index = '0;
                     rsp_valid_in      = 1'b1;
                  end
               end
               default: begin
                  rsp_valid_in = 1'b1;
               end
            endcase
            if (rsp_valid_in) begin
               state_in = lphs_pkg::FSM_IDLE;
            end
         end
         lphs_pkg::FSM_INS: begin
            // place the key at the chosen empty slot, or report full at the load limit or with no free slot
            if (!(have_reuse_ff || have_end_ff) || (count_ff >= {1'b0, max_ff})) begin
               res_in.status     = lphs_pkg::ST_FULL;
               res_in.slot_index = '0;
            end else begin
               mem_we            = 1'b1;
               mem_waddr         = ins_tgt;
               mem_wdata         = {1'b1, have_reuse_ff, key_ff};
               count_in          = count_ff + 11'd1;
               res_in.status     = lphs_pkg::ST_INSERTED;
               res_in.slot_index = slot_of(ins_tgt);
            end
            rsp_valid_in = 1'b1;
            state_in     = lphs_pkg::FSM_IDLE;
         end
         lphs_pkg::FSM_BK_RD: begin
            mem_raddr = prev_slot(pos_ff);
            pos_in    = prev_slot(pos_ff);
            state_in  = lphs_pkg::FSM_BK_EV;
         end
         lphs_pkg::FSM_BK_EV: begin
            // clear continuation marks that no longer lead anywhere
            if (!rd_cont) begin
               rsp_valid_in = 1'b1;
               state_in     = lphs_pkg::FSM_IDLE;
            end else begin
               mem_we    = 1'b1;
               mem_wdata = {rd_occ, 1'b0, rd_key};
               if (rd_occ || last_step) begin
                  rsp_valid_in = 1'b1;
                  state_in     = lphs_pkg::FSM_IDLE;
               end else begin
                  n_in     = n_ff + AW'(1);
                  state_in = lphs_pkg::FSM_BK_RD;
               end
            end
         end
         default: begin
            state_in = lphs_pkg::FSM_IDLE;
         end
      endcase

      if (rsp_valid_in) begin
         res_in.entry_count = count_in;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lphs_pkg::FSM_CLEAR;
         clr_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         max_ff       <= 10'(lphs_pkg::MAX_ENTRIES_RESET);
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            max_ff <= csr_wdata;
         end
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      act_ff        <= act_in;
      res_ff        <= res_in;
      pos_ff        <= pos_in;
      n_ff          <= n_in;
      reuse_ff      <= reuse_in;
      target_ff     <= target_in;
      have_reuse_ff <= have_reuse_in;
      have_end_ff   <= have_end_in;
      key_ff        <= key_in;
   end

   assign busy      = (state_ff != lphs_pkg::FSM_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = res_ff;

   // checks
   `LPHS_ASSERT_IMPLY(a_rsp_when_idle, clock, reset, rsp_valid_ff, state_ff == lphs_pkg::FSM_IDLE)
   `LPHS_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy && !rsp_valid)
   `LPHS_ASSERT_IMPLY(a_full_slot_zero, clock, reset, rsp_valid_ff && (res_ff.status == lphs_pkg::ST_FULL), res_ff.slot_index == 10'd0)

endmodule

FILE: design/lphs_mem.sv
// ----------------------------------------------------------------------------
// lphs_mem
// Single-port-write, single-port-read synchronous slot memory, registered read.
// ----------------------------------------------------------------------------
module lphs_mem #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 34
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, registered
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/lphs_mod.sv
// ----------------------------------------------------------------------------
// lphs_mod
// Reduces a 32-bit hash to a home slot modulo the capacity. A power-of-two
// capacity registers the low bits; otherwise a reciprocal multiply and one
// correcting subtract run through the h_ff, q_ff and r_ff registers.
// ----------------------------------------------------------------------------
module lphs_mod #(
   parameter int CAPACITY = 1024
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [31:0]                 hash_value,
   output logic                        done,
   output logic [$clog2(CAPACITY)-1:0] rem
);

   localparam int AW = $clog2(CAPACITY);
   localparam bit POW2 = ((CAPACITY & (CAPACITY - 1)) == 0);

   generate
      if (POW2) begin : g_pow2
         logic          done_ff;
         logic [AW-1:0] rem_ff;

         // mask off the low bits
         always_ff @(posedge clock) begin
            if (reset) begin
               done_ff <= 1'b0;
            end else begin
               done_ff <= start;
            end
         end

         always_ff @(posedge clock) begin
            if (start) begin
               rem_ff <= hash_value[AW-1:0];
            end
         end

         assign done = done_ff;
         assign rem  = rem_ff;
      end else begin : g_recip
         // reciprocal of the capacity scaled by 2^(32+AW), fits in 33 bits
         localparam int          SH      = 32 + AW;
         localparam logic [63:0] RECIP   = (64'd1 << SH) / CAPACITY;
         localparam logic [32:0] RECIP_W = RECIP[32:0];
         localparam logic [AW:0] CAP_W   = (AW+1)'(CAPACITY);
         localparam logic [31:0] CAP_32  = 32'(CAPACITY);

         logic          v1_ff, v2_ff, done_ff;
         logic [31:0]   h_ff, h2_ff;
         logic [31:0]   q_ff, q_in;
         logic [AW-1:0] r_ff, r_in;
         logic [64:0]   prod;
         logic [63:0]   qc;
         logic [31:0]   diff;
         logic [AW:0]   diff_w;

         // quotient estimate, never high and at most one low
         always_comb begin
            prod = 65'(h_ff) * 65'(RECIP_W);
            q_in = 32'(prod >> SH);
         end

         // remainder from the estimate, below twice the capacity
         always_comb begin
            qc     = 64'(q_ff) * 64'(CAP_32);
            diff   = h2_ff - qc[31:0];
            diff_w = diff[AW:0];
            r_in   = (diff_w >= CAP_W) ? AW'(diff_w - CAP_W) : diff_w[AW-1:0];
         end

         // stage valid bits
         always_ff @(posedge clock) begin
            if (reset) begin
               v1_ff   <= 1'b0;
               v2_ff   <= 1'b0;
               done_ff <= 1'b0;
            end else begin
               v1_ff   <= start;
               v2_ff   <= v1_ff;
               done_ff <= v2_ff;
            end
         end

         // datapath stages
         always_ff @(posedge clock) begin
            if (start) begin
               h_ff <= hash_value;
            end
            h2_ff <= h_ff;
            q_ff  <= q_in;
            r_ff  <= r_in;
         end

         assign done = done_ff;
         assign rem  = r_ff;
      end
   endgenerate

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the linear probe hash set unit. A behavioral copy
// of the set predicts every response. Directed, load-limit, clustered and
// spread random requests are sent in bursts while the load limit is varied.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int         SLOTS      = 1024;
   localparam int         WDOG_LIMIT = 20000;
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   lphs_pkg::req_type req_item;
   logic              rsp_valid;
   lphs_pkg::rsp_type rsp_item;
   logic              csr_we;
   logic [9:0]        csr_wdata;

   // behavioral copy of the set
   logic [31:0] set_keys [SLOTS];
   bit          set_occ  [SLOTS];
   bit          set_cont [SLOTS];
   int unsigned set_count;
   int unsigned set_limit;

   lphs_pkg::rsp_type pending_rsp[$];
   int                mismatch_count;
   int                idle_cycles;
   int                burst_left;

   linear_probe_hash_set_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // expected response for one request, updates the copy of the set
   function automatic lphs_pkg::rsp_type apply_request(lphs_pkg::req_type r);
      lphs_pkg::rsp_type res;
      int unsigned       pos, reuse, target, cur, prv;
      bit                have_reuse, have_end, present;
      res.status     = lphs_pkg::ST_NOTFOUND;
      res.slot_index = '0;
      pos            = r.hash_value[9:0];
      have_reuse     = 0;
      have_end       = 0;
      present        = 0;
      reuse          = 0;
      target         = 0;
      case (r.action)
         lphs_pkg::ACT_FIND, lphs_pkg::ACT_REMOVE: begin
            for (int n = 0; n < SLOTS; n++) begin
               if (set_occ[pos] && set_keys[pos] == r.key) begin
                  res.slot_index = pos[9:0];
                  if (r.action == lphs_pkg::ACT_FIND) begin
                     res.status = lphs_pkg::ST_FOUND;
                  end else begin
                     res.status   = lphs_pkg::ST_REMOVED;
                     set_occ[pos] = 0;
                     cur = pos;
                     // walk back dropping marks that lead nowhere
                     for (int m = 0; m < SLOTS; m++) begin
                        prv = (cur == 0) ? SLOTS - 1 : cur - 1;
                        if (set_occ[cur] || set_cont[cur] || !set_cont[prv]) break;
                        set_cont[prv] = 0;
                        cur = prv;
                     end
                     if (set_count > 0) set_count--;
                  end
                  break;
               end
               if (!set_cont[pos]) break;
               pos = (pos + 1) % SLOTS;
            end
         end
         lphs_pkg::ACT_INSERT: begin
            for (int n = 0; n < SLOTS; n++) begin
               if (set_occ[pos]) begin
                  if (set_keys[pos] == r.key) begin
                     present = 1;
                     res.slot_index = pos[9:0];
                     break;
                  end
                  set_cont[pos] = 1;
               end else if (!set_cont[pos]) begin
                  have_end = 1;
                  target   = pos;
                  break;
               end else if (!have_reuse) begin
                  have_reuse = 1;
                  reuse      = pos;
               end
               pos = (pos + 1) % SLOTS;
            end
            if (present) begin
               res.status = lphs_pkg::ST_PRESENT;
            end else begin
               if (have_reuse) begin
                  target   = reuse;
                  have_end = 1;
               end
               if (!have_end || set_count >= set_limit) begin
                  res.status = lphs_pkg::ST_FULL;
               end else begin
                  set_keys[target] = r.key;
                  set_occ[target]  = 1;
                  set_count        = (set_count + 1) & 11'h7FF;
                  res.status       = lphs_pkg::ST_INSERTED;
                  res.slot_index   = target[9:0];
               end
            end
         end
         default: ;
      endcase
      res.entry_count = set_count[10:0];
      return res;
   endfunction

   // hash that stays fixed per key, home slot confined to a window
   function automatic logic [31:0] hash_of(logic [31:0] k, int unsigned base,
                                           int unsigned window);
      logic [31:0] mix;
      logic [9:0]  home;
      mix  = (k * 32'h9E3779B1) ^ (k >> 13);
      home = 10'((base + (mix[25:10] % window)) % SLOTS);
      return {mix[31:10], home};
   endfunction

   // send one request, hold until accepted; bursts with random gaps
   task automatic send_request(logic [1:0] act, logic [31:0] k, logic [31:0] h);
      lphs_pkg::req_type r;
      if (burst_left == 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat ($urandom_range(0, 6)) @(negedge clock);
         burst_left = $urandom_range(1, 12);
      end
      r.action     = act;
      r.key        = k;
      r.hash_value = h;
      @(negedge clock);
      start    <= 1'b1;
      req_item <= r;
      do @(posedge clock); while (busy);
      pending_rsp.push_back(apply_request(r));
      burst_left--;
   endtask

   // write the load limit once the unit is idle
   task automatic write_limit(logic [9:0] value);
      @(negedge clock);
      start <= 1'b0;
      burst_left = 0;
      wait (pending_rsp.size() == 0);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
      set_limit = value;
   endtask

   // directed corner cases at the reset limit
   task automatic test_directed();
      send_request(lphs_pkg::ACT_FIND,   32'h0, 32'h0);
      send_request(lphs_pkg::ACT_REMOVE, 32'h5, 32'h5);
      send_request(ACT_UNUSED,           32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(lphs_pkg::ACT_INSERT, 32'h0, 32'h0);
      // chain at the top slot wraps to slot zero
      send_request(lphs_pkg::ACT_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(lphs_pkg::ACT_INSERT, 32'hAAAA_AAAA, 32'h0000_03FF);
      send_request(lphs_pkg::ACT_INSERT, 32'h5555_5555, 32'hFFFF_FFFF);
      send_request(lphs_pkg::ACT_INSERT, 32'hAAAA_AAAA, 32'h0000_03FF);
      send_request(lphs_pkg::ACT_FIND,   32'h5555_5555, 32'hFFFF_FFFF);
      send_request(lphs_pkg::ACT_FIND,   32'h1234_5678, 32'h0000_03FF);
      // hole in the middle of a chain, then reuse it
      send_request(lphs_pkg::ACT_REMOVE, 32'hAAAA_AAAA, 32'h0000_03FF);
      send_request(lphs_pkg::ACT_FIND,   32'h5555_5555, 32'hFFFF_FFFF);
      send_request(lphs_pkg::ACT_INSERT, 32'h0BAD_F00D, 32'h0000_03FF);
      // removing chain ends cleans marks backward
      send_request(lphs_pkg::ACT_REMOVE, 32'h5555_5555, 32'hFFFF_FFFF);
      send_request(lphs_pkg::ACT_REMOVE, 32'h0000_0000, 32'h0000_0000);
      send_request(lphs_pkg::ACT_REMOVE, 32'h0BAD_F00D, 32'h0000_03FF);
      send_request(lphs_pkg::ACT_REMOVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(lphs_pkg::ACT_REMOVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(lphs_pkg::ACT_FIND,   32'hFFFF_FFFF, 32'h0000_0000);
   endtask

   // inserts refused at a small load limit
   task automatic test_load_limit(logic [9:0] value);
      write_limit(value);
      for (int i = 0; i < 12; i++)
         send_request(lphs_pkg::ACT_INSERT, 32'h7000_0000 + i, 32'h0000_0200 + (i % 3));
      send_request(lphs_pkg::ACT_INSERT, 32'h7000_0000, 32'h0000_0200);
      for (int i = 0; i < 12; i++)
         send_request(lphs_pkg::ACT_REMOVE, 32'h7000_0000 + i, 32'h0000_0200 + (i % 3));
   endtask

   // random mix over a key pool; pool and window set how deep chains get
   task automatic test_random_mix(int count, int unsigned pool, int unsigned window);
      logic [31:0] key_base, k, h;
      int unsigned hash_base, pick;
      logic [1:0]  act;
      key_base  = $urandom();
      hash_base = $urandom_range(0, SLOTS - 1);
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         act  = (pick < 45) ? lphs_pkg::ACT_INSERT : (pick < 70) ? lphs_pkg::ACT_FIND :
                (pick < 96) ? lphs_pkg::ACT_REMOVE : ACT_UNUSED;
         if ($urandom_range(0, 19) == 0) begin
            k = $urandom();
            h = $urandom();
         end else begin
            k = key_base ^ $urandom_range(0, pool - 1);
            h = hash_of(k, hash_base, window);
         end
         send_request(act, k, h);
      end
   endtask

   // response checker
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_rsp.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected response %p", rsp_item);
         end else begin
            lphs_pkg::rsp_type exp_rsp;
            exp_rsp = pending_rsp.pop_front();
            if (rsp_item !== exp_rsp) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: expected %p, got %p", exp_rsp, rsp_item);
            end
         end
      end
   end

   // watchdog on cycles with no progress
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WDOG_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // test sequence
   initial begin
      reset          = 1'b1;
      start          = 1'b0;
      req_item       = '0;
      csr_we         = 1'b0;
      csr_wdata      = '0;
      mismatch_count = 0;
      idle_cycles    = 0;
      burst_left     = 0;
      set_count      = 0;
      set_limit      = lphs_pkg::MAX_ENTRIES_RESET;
      for (int i = 0; i < SLOTS; i++) begin
         set_occ[i]  = 0;
         set_cont[i] = 0;
      end
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_load_limit(10'd1);
      test_load_limit(10'd8);
      write_limit(10'd1023);
      test_random_mix(700, 48, 6);
      write_limit(10'd20);
      test_random_mix(300, 40, 4);
      write_limit(10'd1023);
      test_random_mix(700, 1400, SLOTS);
      write_limit(10'd512);
      test_random_mix(300, 64, 16);

      @(negedge clock);
      start <= 1'b0;
      wait (pending_rsp.size() == 0);
      repeat (50) @(posedge clock);
      if (mismatch_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end
endmodule
